[design/rhbp_pkg.sv]
// Shared types, codes and the field layout table for the replay header byte parser.
package rhbp_pkg;

    localparam logic [4:0] FIELD_MODE      = 5'd0;
    localparam logic [4:0] FIELD_BLOCK_LEN = 5'd17;
    localparam logic [4:0] FIELD_BLOCK     = 5'd18;
    localparam logic [4:0] FIELD_TAIL      = 5'd19;
    localparam logic [4:0] FIELD_DONE      = 5'd20;

    localparam logic [3:0] SZ_STR = 4'd0;
    localparam logic [3:0] SZ_RAW = 4'd15;

    localparam logic [7:0] MARK_ABSENT  = 8'd0;
    localparam logic [7:0] MARK_PRESENT = 8'd11;
    localparam logic [63:0] MODE_MAX    = 64'd3;

    localparam logic [2:0] KIND_NUMBER  = 3'd0;
    localparam logic [2:0] KIND_LENGTH  = 3'd1;
    localparam logic [2:0] KIND_PAYLOAD = 3'd2;
    localparam logic [2:0] KIND_ABSENT  = 3'd3;
    localparam logic [2:0] KIND_ERROR   = 3'd4;

    localparam logic [2:0] ERR_NONE       = 3'd0;
    localparam logic [2:0] ERR_EARLY_END  = 3'd1;
    localparam logic [2:0] ERR_BAD_MARKER = 3'd2;
    localparam logic [2:0] ERR_VARINT     = 3'd3;
    localparam logic [2:0] ERR_BAD_MODE   = 3'd4;
    localparam logic [2:0] ERR_TRAILING   = 3'd5;

    typedef enum logic [2:0] {
        PH_MARKER  = 3'b001,
        PH_LENGTH  = 3'b010,
        PH_PAYLOAD = 3'b100
    } phase_t;

    typedef struct packed {
        logic [4:0]  field_index;
        logic [3:0]  byte_count;
        logic [63:0] accumulator;
        phase_t      phase;
        logic [31:0] payload_left;
        logic        skip;
    } state_t;

    typedef struct packed {
        logic        have;
        logic [4:0]  field_id;
        logic [2:0]  kind;
        logic [63:0] value;
        logic [2:0]  error_code;
        logic        record_end;
    } result_t;

    localparam state_t STATE_RESET = '{
        field_index:  5'd0,
        byte_count:   4'd0,
        accumulator:  64'd0,
        phase:        PH_MARKER,
        payload_left: 32'd0,
        skip:         1'b0
    };

    function automatic logic [3:0] field_size(input logic [4:0] idx);
        logic [3:0] sz;
        case (idx)
            5'd0:    sz = 4'd1;
            5'd1:    sz = 4'd4;
            5'd2:    sz = SZ_STR;
            5'd3:    sz = SZ_STR;
            5'd4:    sz = SZ_STR;
            5'd5:    sz = 4'd2;
            5'd6:    sz = 4'd2;
            5'd7:    sz = 4'd2;
            5'd8:    sz = 4'd2;
            5'd9:    sz = 4'd2;
            5'd10:   sz = 4'd2;
            5'd11:   sz = 4'd4;
            5'd12:   sz = 4'd2;
            5'd13:   sz = 4'd1;
            5'd14:   sz = 4'd4;
            5'd15:   sz = SZ_STR;
            5'd16:   sz = 4'd8;
            5'd17:   sz = 4'd4;
            5'd18:   sz = SZ_RAW;
            5'd19:   sz = 4'd8;
            default: sz = SZ_STR;
        endcase
        return sz;
    endfunction

endpackage

[design/rhbp_step.sv]
// Next-state and result logic for one byte of the replay header parser.
module rhbp_step #(
    parameter int VARINT_MAX_BYTES = 4
) (
    input  rhbp_pkg::state_t  cur,
    input  logic [7:0]        data_byte,
    input  logic              last_byte,
    output rhbp_pkg::state_t  nxt,
    output rhbp_pkg::result_t res
);

    logic [3:0]        size;
    logic              is_payload;
    logic [3:0]        count_inc;
    logic [63:0]       num_acc;
    logic [5:0]        var_shift;
    logic [63:0]       var_acc;
    rhbp_pkg::state_t  advanced;
    rhbp_pkg::state_t  walk;
    rhbp_pkg::result_t found;
    logic [2:0]        err;
    logic [4:0]        err_field;
    logic [63:0]       err_value;

    assign size       = rhbp_pkg::field_size(cur.field_index);
    assign is_payload = (size == rhbp_pkg::SZ_RAW)
                     || ((size == rhbp_pkg::SZ_STR) && (cur.phase == rhbp_pkg::PH_PAYLOAD));
    assign count_inc  = cur.byte_count + 4'd1;
    assign num_acc    = cur.accumulator | (64'(data_byte) << {cur.byte_count[2:0], 3'b000});
    assign var_shift  = 6'(cur.byte_count[2:0]) * 6'd7;
    assign var_acc    = cur.accumulator | (64'(data_byte[6:0]) << var_shift);

    always_comb
    begin
        advanced             = cur;
        advanced.field_index = cur.field_index + 5'd1;
        advanced.byte_count  = 4'd0;
        advanced.accumulator = 64'd0;
        advanced.phase       = rhbp_pkg::PH_MARKER;
    end

    always_comb
    begin
        walk      = cur;
        found     = '0;
        err       = rhbp_pkg::ERR_NONE;
        err_field = 5'd0;
        err_value = 64'd0;
        if (cur.field_index >= rhbp_pkg::FIELD_DONE)
        begin
            err       = rhbp_pkg::ERR_TRAILING;
            err_field = rhbp_pkg::FIELD_TAIL;
        end
        else if (is_payload)
        begin
            found.have     = 1'b1;
            found.field_id = cur.field_index;
            found.kind     = rhbp_pkg::KIND_PAYLOAD;
            found.value    = 64'(data_byte);
            if (cur.payload_left <= 32'd1)
            begin
                walk              = advanced;
                walk.payload_left = 32'd0;
            end
            else
            begin
                walk.payload_left = cur.payload_left - 32'd1;
            end
        end
        else if (size == rhbp_pkg::SZ_STR)
        begin
            case (cur.phase)
                rhbp_pkg::PH_MARKER:
                begin
                    if (data_byte == rhbp_pkg::MARK_ABSENT)
                    begin
                        found.have     = 1'b1;
                        found.field_id = cur.field_index;
                        found.kind     = rhbp_pkg::KIND_ABSENT;
                        walk           = advanced;
                    end
                    else if (data_byte == rhbp_pkg::MARK_PRESENT)
                    begin
                        walk.phase       = rhbp_pkg::PH_LENGTH;
                        walk.byte_count  = 4'd0;
                        walk.accumulator = 64'd0;
                    end
                    else
                    begin
                        err       = rhbp_pkg::ERR_BAD_MARKER;
                        err_field = cur.field_index;
                        err_value = 64'(data_byte);
                    end
                end
                rhbp_pkg::PH_LENGTH:
                begin
                    if (data_byte[7])
                    begin
                        if (count_inc >= 4'(VARINT_MAX_BYTES))
                        begin
                            err       = rhbp_pkg::ERR_VARINT;
                            err_field = cur.field_index;
                        end
                        else
                        begin
                            walk.byte_count  = count_inc;
                            walk.accumulator = var_acc;
                        end
                    end
                    else
                    begin
                        found.have     = 1'b1;
                        found.field_id = cur.field_index;
                        found.kind     = rhbp_pkg::KIND_LENGTH;
                        found.value    = 64'(var_acc[31:0]);
                        if (var_acc[31:0] == 32'd0)
                        begin
                            walk = advanced;
                        end
                        else
                        begin
                            walk.phase        = rhbp_pkg::PH_PAYLOAD;
                            walk.payload_left = var_acc[31:0];
                            walk.byte_count   = 4'd0;
                            walk.accumulator  = 64'd0;
                        end
                    end
                end
                default:
                begin
                    walk = cur;
                end
            endcase
        end
        else
        begin
            walk.byte_count  = count_inc;
            walk.accumulator = num_acc;
            if (count_inc >= size)
            begin
                if ((cur.field_index == rhbp_pkg::FIELD_MODE) && (num_acc > rhbp_pkg::MODE_MAX))
                begin
                    err       = rhbp_pkg::ERR_BAD_MODE;
                    err_field = rhbp_pkg::FIELD_MODE;
                    err_value = num_acc;
                end
                else
                begin
                    found.have     = 1'b1;
                    found.field_id = cur.field_index;
                    found.kind     = rhbp_pkg::KIND_NUMBER;
                    found.value    = num_acc;
                    walk           = advanced;
                    if (cur.field_index == rhbp_pkg::FIELD_BLOCK_LEN)
                    begin
                        walk.payload_left = num_acc[31:0];
                        walk.field_index  = (num_acc[31:0] == 32'd0) ? rhbp_pkg::FIELD_TAIL
                                                                     : rhbp_pkg::FIELD_BLOCK;
                    end
                end
            end
        end
    end

    always_comb
    begin
        nxt = walk;
        res = found;
        if (cur.skip)
        begin
            res = '0;
            nxt = cur;
            if (last_byte)
            begin
                nxt = rhbp_pkg::STATE_RESET;
            end
        end
        else if (err != rhbp_pkg::ERR_NONE)
        begin
            res.have       = 1'b1;
            res.field_id   = err_field;
            res.kind       = rhbp_pkg::KIND_ERROR;
            res.value      = err_value;
            res.error_code = err;
            res.record_end = 1'b1;
            nxt            = rhbp_pkg::STATE_RESET;
            nxt.skip       = !last_byte;
        end
        else if (last_byte)
        begin
            if (walk.field_index >= rhbp_pkg::FIELD_DONE)
            begin
                res.record_end = 1'b1;
            end
            else
            begin
                res.have       = 1'b1;
                res.field_id   = walk.field_index;
                res.kind       = rhbp_pkg::KIND_ERROR;
                res.value      = 64'd0;
                res.error_code = rhbp_pkg::ERR_EARLY_END;
                res.record_end = 1'b1;
            end
            nxt = rhbp_pkg::STATE_RESET;
        end
    end

endmodule

[design/replay_header_byte_parser.sv]
// Each accepted byte goes into the input register; its result, if any, is written to the output register.
// Throughput: one byte per cycle unless out_stall holds back a pending result; the parse state
// updates once per byte in a single pass between the input register and the output register.
// A byte that yields no result still passes through the input register.
// Reset (rst_n low, asynchronous) empties both registers and returns parsing to field 0.
// Parsing also restarts at field 0 after every byte marked last.
module replay_header_byte_parser #(
    parameter int VARINT_MAX_BYTES = 4
) (
    input  logic        clk,
    input  logic        rst_n,
    input  logic        in_valid,
    output logic        in_stall,
    input  logic [7:0]  data_byte,
    input  logic        last_byte,
    output logic        out_valid,
    input  logic        out_stall,
    output logic [4:0]  field_id,
    output logic [2:0]  kind,
    output logic [63:0] value,
    output logic [2:0]  error_code,
    output logic        record_end
);

    logic              in_valid_reg;
    logic [7:0]        data_reg;
    logic              last_reg;
    rhbp_pkg::state_t  state_reg;
    rhbp_pkg::state_t  state_next;
    rhbp_pkg::result_t step_res;
    logic              out_valid_reg;
    rhbp_pkg::result_t out_reg;
    logic              process_go;

    assign process_go = in_valid_reg && (!out_valid_reg || !out_stall);
    assign in_stall   = in_valid_reg && !process_go;

    rhbp_step #(
        .VARINT_MAX_BYTES(VARINT_MAX_BYTES)
    ) u_step (
        .cur       (state_reg),
        .data_byte (data_reg),
        .last_byte (last_reg),
        .nxt       (state_next),
        .res       (step_res)
    );

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            in_valid_reg  <= 1'b0;
            out_valid_reg <= 1'b0;
            state_reg     <= rhbp_pkg::STATE_RESET;
        end
        else
        begin
            if (!in_stall)
            begin
                in_valid_reg <= in_valid;
            end
            if (process_go)
            begin
                state_reg     <= state_next;
                out_valid_reg <= step_res.have;
            end
            else if (!out_stall)
            begin
                out_valid_reg <= 1'b0;
            end
        end
    end

    always_ff @(posedge clk)
    begin
        if (in_valid && !in_stall)
        begin
            data_reg <= data_byte;
            last_reg <= last_byte;
        end
        if (process_go && step_res.have)
        begin
            out_reg <= step_res;
        end
    end

    assign out_valid  = out_valid_reg;
    assign field_id   = out_reg.field_id;
    assign kind       = out_reg.kind;
    assign value      = out_reg.value;
    assign error_code = out_reg.error_code;
    assign record_end = out_reg.record_end;

`ifndef ASSERT_OFF
    a_err_code_kind: assert property (@(posedge clk) disable iff (!rst_n)
        out_valid |-> ((kind == rhbp_pkg::KIND_ERROR) == (error_code != rhbp_pkg::ERR_NONE)))
        else $error("error code does not match result kind");

    a_err_ends_record: assert property (@(posedge clk) disable iff (!rst_n)
        (out_valid && (kind == rhbp_pkg::KIND_ERROR)) |-> record_end)
        else $error("error result without record end");

    a_skip_from_clean: assert property (@(posedge clk) disable iff (!rst_n)
        state_reg.skip |-> ((state_reg.field_index == rhbp_pkg::FIELD_MODE)
                            && (state_reg.phase == rhbp_pkg::PH_MARKER)))
        else $error("skipping with unfinished parse state");

    a_index_range: assert property (@(posedge clk) disable iff (!rst_n)
        state_reg.field_index <= rhbp_pkg::FIELD_DONE)
        else $error("field index beyond done");
`endif

endmodule

[sim/tb.sv]
// Testbench for the replay header byte parser: directed table, then random files vs a predictor.
module tb;
    timeunit 1ns;
    timeprecision 1ps;

    localparam int VARINT_LIMIT = 4;
    localparam int ITEM_TARGET  = 1850;
    localparam int CALM_TAIL    = 150;

    localparam logic [4:0] FIELD_VERSION = 5'd1;
    localparam logic [4:0] FIELD_TEXT_1  = 5'd2;
    localparam logic [4:0] FIELD_TEXT_2  = 5'd3;
    localparam logic [4:0] FIELD_TEXT_3  = 5'd4;

    localparam logic [3:0] FIELD_BYTES [20] = '{
        4'd1, 4'd4, rhbp_pkg::SZ_STR, rhbp_pkg::SZ_STR, rhbp_pkg::SZ_STR,
        4'd2, 4'd2, 4'd2, 4'd2, 4'd2,
        4'd2, 4'd4, 4'd2, 4'd1, 4'd4, rhbp_pkg::SZ_STR,
        4'd8, 4'd4, rhbp_pkg::SZ_RAW, 4'd8
    };

    typedef struct packed {
        logic [4:0]  field_id;
        logic [2:0]  kind;
        logic [63:0] value;
        logic [2:0]  error_code;
        logic        record_end;
    } parse_result_t;

    typedef struct packed {
        logic [7:0]    b;
        logic          lst;
        logic [2:0]    reps;
        logic          typed;
        logic          has;
        parse_result_t res;
    } stim_row_t;

    localparam parse_result_t NO_RES = '0;

    localparam stim_row_t DIRECTED [24] = '{
        '{8'h04, 1'b0, 3'd1, 1'b1, 1'b1,
          '{rhbp_pkg::FIELD_MODE, rhbp_pkg::KIND_ERROR, 64'd4, rhbp_pkg::ERR_BAD_MODE, 1'b1}},
        '{8'hFF, 1'b0, 3'd1, 1'b1, 1'b0, NO_RES},
        '{8'h00, 1'b1, 3'd1, 1'b1, 1'b0, NO_RES},
        '{8'hFF, 1'b1, 3'd1, 1'b1, 1'b1,
          '{rhbp_pkg::FIELD_MODE, rhbp_pkg::KIND_ERROR, 64'd255, rhbp_pkg::ERR_BAD_MODE, 1'b1}},
        '{8'h00, 1'b0, 3'd1, 1'b1, 1'b1,
          '{rhbp_pkg::FIELD_MODE, rhbp_pkg::KIND_NUMBER, 64'd0, rhbp_pkg::ERR_NONE, 1'b0}},
        '{8'hFF, 1'b0, 3'd3, 1'b0, 1'b0, NO_RES},
        '{8'hFF, 1'b0, 3'd1, 1'b1, 1'b1,
          '{FIELD_VERSION, rhbp_pkg::KIND_NUMBER, 64'hFFFF_FFFF, rhbp_pkg::ERR_NONE, 1'b0}},
        '{8'h00, 1'b0, 3'd1, 1'b1, 1'b1,
          '{FIELD_TEXT_1, rhbp_pkg::KIND_ABSENT, 64'd0, rhbp_pkg::ERR_NONE, 1'b0}},
        '{rhbp_pkg::MARK_PRESENT, 1'b0, 3'd1, 1'b1, 1'b0, NO_RES},
        '{8'h00, 1'b0, 3'd1, 1'b1, 1'b1,
          '{FIELD_TEXT_2, rhbp_pkg::KIND_LENGTH, 64'd0, rhbp_pkg::ERR_NONE, 1'b0}},
        '{rhbp_pkg::MARK_PRESENT, 1'b0, 3'd1, 1'b1, 1'b0, NO_RES},
        '{8'h81, 1'b0, 3'd1, 1'b0, 1'b0, NO_RES},
        '{8'h80, 1'b0, 3'd1, 1'b0, 1'b0, NO_RES},
        '{8'hFF, 1'b0, 3'd1, 1'b0, 1'b0, NO_RES},
        '{8'hFF, 1'b0, 3'd1, 1'b1, 1'b1,
          '{FIELD_TEXT_3, rhbp_pkg::KIND_ERROR, 64'd0, rhbp_pkg::ERR_VARINT, 1'b1}},
        '{8'h00, 1'b1, 3'd1, 1'b1, 1'b0, NO_RES},
        '{8'h03, 1'b0, 3'd1, 1'b1, 1'b1,
          '{rhbp_pkg::FIELD_MODE, rhbp_pkg::KIND_NUMBER, 64'd3, rhbp_pkg::ERR_NONE, 1'b0}},
        '{8'h00, 1'b1, 3'd1, 1'b1, 1'b1,
          '{FIELD_VERSION, rhbp_pkg::KIND_ERROR, 64'd0, rhbp_pkg::ERR_EARLY_END, 1'b1}},
        '{8'h01, 1'b0, 3'd1, 1'b0, 1'b0, NO_RES},
        '{8'h00, 1'b0, 3'd4, 1'b0, 1'b0, NO_RES},
        '{rhbp_pkg::MARK_PRESENT, 1'b0, 3'd1, 1'b1, 1'b0, NO_RES},
        '{8'h01, 1'b0, 3'd1, 1'b1, 1'b1,
          '{FIELD_TEXT_1, rhbp_pkg::KIND_LENGTH, 64'd1, rhbp_pkg::ERR_NONE, 1'b0}},
        '{8'h5A, 1'b0, 3'd1, 1'b1, 1'b1,
          '{FIELD_TEXT_1, rhbp_pkg::KIND_PAYLOAD, 64'h5A, rhbp_pkg::ERR_NONE, 1'b0}},
        '{8'h0C, 1'b1, 3'd1, 1'b1, 1'b1,
          '{FIELD_TEXT_2, rhbp_pkg::KIND_ERROR, 64'd12, rhbp_pkg::ERR_BAD_MARKER, 1'b1}}
    };

    logic        clk;
    logic        rst_n;
    logic        in_valid;
    logic        in_stall;
    logic [7:0]  data_byte;
    logic        last_byte;
    logic        out_valid;
    logic        out_stall;
    logic [4:0]  field_id;
    logic [2:0]  kind;
    logic [63:0] value;
    logic [2:0]  error_code;
    logic        record_end;

    logic [4:0]        hdr_field;
    logic [3:0]        hdr_count;
    logic [63:0]       hdr_acc;
    rhbp_pkg::phase_t  hdr_phase;
    logic [31:0]       hdr_left;
    logic              hdr_skip;

    parse_result_t parsed_q[$];
    logic [7:0]    file_bytes[$];
    int            mismatch_count;
    int            items_sent;
    int            hold_span;
    bit            gaps_on;

    replay_header_byte_parser #(
        .VARINT_MAX_BYTES(VARINT_LIMIT)
    ) u_top (
        .clk       (clk),
        .rst_n     (rst_n),
        .in_valid  (in_valid),
        .in_stall  (in_stall),
        .data_byte (data_byte),
        .last_byte (last_byte),
        .out_valid (out_valid),
        .out_stall (out_stall),
        .field_id  (field_id),
        .kind      (kind),
        .value     (value),
        .error_code(error_code),
        .record_end(record_end)
    );

    initial
    begin
        clk = 1'b0;
        forever #5 clk = ~clk;
    end

    initial
    begin
        #5_000_000;
        $display("RESULT: ERROR");
        $finish;
    end

    function automatic void clear_parse();
        hdr_field = '0;
        hdr_count = '0;
        hdr_acc   = '0;
        hdr_phase = rhbp_pkg::PH_MARKER;
        hdr_left  = '0;
    endfunction

    function automatic void next_field();
        if (hdr_field < rhbp_pkg::FIELD_DONE)
            hdr_field++;
        hdr_count = '0;
        hdr_acc   = '0;
        hdr_phase = rhbp_pkg::PH_MARKER;
    endfunction

    function automatic void parse_header_byte(input logic [7:0] b, input logic lst,
                                              output bit has, output parse_result_t res);
        logic [4:0]  fi;
        logic [4:0]  ef;
        logic [2:0]  err;
        logic [63:0] ev;
        logic [3:0]  sz;
        logic [31:0] len;
        int          sh;
        has = 1'b0;
        res = '0;
        err = rhbp_pkg::ERR_NONE;
        ef  = '0;
        ev  = '0;
        if (hdr_skip)
        begin
            if (lst)
            begin
                clear_parse();
                hdr_skip = 1'b0;
            end
            return;
        end
        if (hdr_field >= rhbp_pkg::FIELD_DONE)
        begin
            err = rhbp_pkg::ERR_TRAILING;
            ef  = rhbp_pkg::FIELD_TAIL;
        end
        else
        begin
            fi = hdr_field;
            sz = FIELD_BYTES[fi];
            if (sz == rhbp_pkg::SZ_RAW
                || (sz == rhbp_pkg::SZ_STR && hdr_phase == rhbp_pkg::PH_PAYLOAD))
            begin
                has = 1'b1;
                res = '{fi, rhbp_pkg::KIND_PAYLOAD, 64'(b), rhbp_pkg::ERR_NONE, 1'b0};
                if (hdr_left <= 1)
                begin
                    hdr_left = '0;
                    next_field();
                end
                else
                    hdr_left--;
            end
            else if (sz == rhbp_pkg::SZ_STR && hdr_phase == rhbp_pkg::PH_MARKER)
            begin
                if (b == rhbp_pkg::MARK_ABSENT)
                begin
                    has = 1'b1;
                    res = '{fi, rhbp_pkg::KIND_ABSENT, 64'd0, rhbp_pkg::ERR_NONE, 1'b0};
                    next_field();
                end
                else if (b == rhbp_pkg::MARK_PRESENT)
                begin
                    hdr_phase = rhbp_pkg::PH_LENGTH;
                    hdr_count = '0;
                    hdr_acc   = '0;
                end
                else
                begin
                    err = rhbp_pkg::ERR_BAD_MARKER;
                    ef  = fi;
                    ev  = 64'(b);
                end
            end
            else if (sz == rhbp_pkg::SZ_STR)
            begin
                sh = (hdr_count < 5 ? int'(hdr_count) : 4) * 7;
                hdr_acc = hdr_acc + (64'(b[6:0]) << sh);
                hdr_count++;
                if (b[7])
                begin
                    if (hdr_count >= VARINT_LIMIT)
                    begin
                        err = rhbp_pkg::ERR_VARINT;
                        ef  = fi;
                    end
                end
                else
                begin
                    len = hdr_acc[31:0];
                    has = 1'b1;
                    res = '{fi, rhbp_pkg::KIND_LENGTH, 64'(len), rhbp_pkg::ERR_NONE, 1'b0};
                    if (len == 0)
                        next_field();
                    else
                    begin
                        hdr_phase = rhbp_pkg::PH_PAYLOAD;
                        hdr_left  = len;
                        hdr_count = '0;
                        hdr_acc   = '0;
                    end
                end
            end
            else
            begin
                sh = (hdr_count < 8 ? int'(hdr_count) : 7) * 8;
                hdr_acc = hdr_acc | (64'(b) << sh);
                hdr_count++;
                if (hdr_count >= sz)
                begin
                    if (fi == rhbp_pkg::FIELD_MODE && hdr_acc > rhbp_pkg::MODE_MAX)
                    begin
                        err = rhbp_pkg::ERR_BAD_MODE;
                        ef  = rhbp_pkg::FIELD_MODE;
                        ev  = hdr_acc;
                    end
                    else
                    begin
                        has = 1'b1;
                        res = '{fi, rhbp_pkg::KIND_NUMBER, hdr_acc, rhbp_pkg::ERR_NONE, 1'b0};
                        next_field();
                        if (fi == rhbp_pkg::FIELD_BLOCK_LEN)
                        begin
                            hdr_left = res.value[31:0];
                            if (hdr_left == 0)
                                next_field();
                        end
                    end
                end
            end
        end
        if (err != rhbp_pkg::ERR_NONE)
        begin
            has = 1'b1;
            res = '{ef, rhbp_pkg::KIND_ERROR, ev, err, 1'b1};
            clear_parse();
            if (!lst)
                hdr_skip = 1'b1;
        end
        else if (lst)
        begin
            if (hdr_field >= rhbp_pkg::FIELD_DONE)
                res.record_end = 1'b1;
            else
            begin
                has = 1'b1;
                res = '{hdr_field, rhbp_pkg::KIND_ERROR, 64'd0, rhbp_pkg::ERR_EARLY_END, 1'b1};
            end
            clear_parse();
        end
    endfunction

    task automatic send_byte(input logic [7:0] b, input logic lst, input bit typed = 1'b0,
                             input bit typed_has = 1'b0, input parse_result_t typed_res = '0);
        bit            has;
        bit            was_skipping;
        parse_result_t res;
        if (gaps_on && $urandom_range(0, 7) == 0)
        begin
            in_valid <= 1'b0;
            repeat ($urandom_range(1, 12)) @(negedge clk);
        end
        in_valid  <= 1'b1;
        data_byte <= b;
        last_byte <= lst;
        @(posedge clk);
        while (in_stall)
            @(posedge clk);
        was_skipping = hdr_skip;
        parse_header_byte(b, lst, has, res);
        if (typed)
        begin
            has = typed_has;
            res = typed_res;
        end
        if (has)
            parsed_q.push_back(res);
        if (!was_skipping)
            items_sent++;
        @(negedge clk);
    endtask

    function automatic logic [63:0] rand_word();
        case ($urandom_range(0, 7))
            0:       return '1;
            1:       return '0;
            default: return {$urandom, $urandom};
        endcase
    endfunction

    function automatic void put_le(input logic [63:0] v, input int n);
        for (int i = 0; i < n; i++)
            file_bytes.push_back(v[8*i +: 8]);
    endfunction

    function automatic void put_string();
        int len;
        int minb;
        int nb;
        if ($urandom_range(0, 4) == 0)
        begin
            file_bytes.push_back(rhbp_pkg::MARK_ABSENT);
            return;
        end
        file_bytes.push_back(rhbp_pkg::MARK_PRESENT);
        case ($urandom_range(0, 19))
            0:       len = $urandom_range(128, 160);
            1, 2, 3: len = $urandom_range(5, 30);
            default: len = $urandom_range(0, 4);
        endcase
        minb = (len < 128) ? 1 : 2;
        nb = ($urandom_range(0, 3) == 0) ? $urandom_range(minb, VARINT_LIMIT) : minb;
        for (int i = 0; i < nb; i++)
            file_bytes.push_back({(i < nb - 1) ? 1'b1 : 1'b0, 7'(len >> (7 * i))});
        repeat (len)
            file_bytes.push_back(8'($urandom));
    endfunction

    function automatic void build_file();
        logic [31:0] blk;
        file_bytes.delete();
        file_bytes.push_back(8'($urandom_range(0, 3)));
        put_le(rand_word(), 4);
        repeat (3)
            put_string();
        repeat (6)
            put_le(rand_word(), 2);
        put_le(rand_word(), 4);
        put_le(rand_word(), 2);
        put_le(rand_word(), 1);
        put_le(rand_word(), 4);
        put_string();
        put_le(rand_word(), 8);
        blk = ($urandom_range(0, 4) == 0) ? 32'd0 : 32'($urandom_range(1, 12));
        put_le(64'(blk), 4);
        repeat (blk)
            file_bytes.push_back(8'($urandom));
        put_le(rand_word(), 8);
    endfunction

    initial
    begin : receiver
        int span;
        out_stall = 1'b0;
        forever
        begin
            @(negedge clk);
            if (hold_span > 0)
            begin
                span = hold_span;
                hold_span = 0;
                out_stall <= 1'b1;
                repeat (span - 1) @(negedge clk);
            end
            else if (gaps_on && $urandom_range(0, 9) == 0)
            begin
                out_stall <= 1'b1;
                repeat ($urandom_range(0, 11)) @(negedge clk);
            end
            else
                out_stall <= 1'b0;
        end
    end

    always @(posedge clk)
    begin
        parse_result_t seen;
        parse_result_t want;
        if (rst_n && out_valid && !out_stall)
        begin
            seen = '{field_id, kind, value, error_code, record_end};
            if (parsed_q.size() == 0)
            begin
                mismatch_count++;
                if (mismatch_count <= 10)
                    $display("%0t: unexpected item: field %0d kind %0d value %h err %0d end %0b",
                             $realtime, seen.field_id, seen.kind, seen.value,
                             seen.error_code, seen.record_end);
            end
            else
            begin
                want = parsed_q.pop_front();
                if (seen.field_id !== want.field_id || seen.kind !== want.kind ||
                    seen.value !== want.value || seen.error_code !== want.error_code ||
                    seen.record_end !== want.record_end)
                begin
                    mismatch_count++;
                    if (mismatch_count <= 10)
                        $display("%0t: got field %0d kind %0d value %h err %0d end %0b, %s",
                                 $realtime, seen.field_id, seen.kind, seen.value,
                                 seen.error_code, seen.record_end,
                                 $sformatf("want field %0d kind %0d value %h err %0d end %0b",
                                           want.field_id, want.kind, want.value,
                                           want.error_code, want.record_end));
                end
            end
        end
    end

    initial
    begin : stimulus
        int  sel;
        int  n;
        bit  drained_once;
        rst_n          = 1'b0;
        in_valid       = 1'b0;
        data_byte      = '0;
        last_byte      = 1'b0;
        mismatch_count = 0;
        items_sent     = 0;
        hold_span      = 0;
        gaps_on        = 1'b1;
        drained_once   = 1'b0;
        hdr_skip       = 1'b0;
        clear_parse();
        repeat (12) @(negedge clk);
        rst_n <= 1'b1;
        @(negedge clk);

        for (int r = 0; r < $size(DIRECTED); r++)
            repeat (DIRECTED[r].reps)
                send_byte(DIRECTED[r].b, DIRECTED[r].lst, DIRECTED[r].typed,
                          DIRECTED[r].has, DIRECTED[r].res);

        hold_span = 300;
        while (items_sent < ITEM_TARGET)
        begin
            gaps_on = (items_sent < ITEM_TARGET - CALM_TAIL) && ($urandom_range(0, 3) != 0);
            if (!drained_once && items_sent >= ITEM_TARGET / 2)
            begin
                drained_once = 1'b1;
                in_valid <= 1'b0;
                while (parsed_q.size() != 0)
                    @(posedge clk);
                @(negedge clk);
            end
            sel = $urandom_range(0, 19);
            if (sel < 2)
            begin
                n = $urandom_range(1, 20);
                for (int i = 0; i < n; i++)
                    send_byte(8'($urandom), (i == n - 1) || ($urandom_range(0, 15) == 0));
            end
            else
            begin
                build_file();
                if (sel < 6)
                    file_bytes[$urandom_range(0, file_bytes.size() - 1)] = 8'($urandom);
                else if (sel < 9)
                    repeat ($urandom_range(1, file_bytes.size() - 1))
                        void'(file_bytes.pop_back());
                else if (sel < 12)
                    repeat ($urandom_range(1, 3))
                        file_bytes.push_back(8'($urandom));
                for (int i = 0; i < file_bytes.size(); i++)
                    send_byte(file_bytes[i], i == file_bytes.size() - 1);
            end
        end

        in_valid <= 1'b0;
        while (parsed_q.size() != 0)
            @(posedge clk);
        repeat (10) @(posedge clk);
        if (mismatch_count == 0)
            $display("RESULT: OK");
        else
            $display("RESULT: ERROR");
        $finish;
    end
endmodule
